[hdl/assert_macros.svh]
// Assertion macros used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, expr, msg)
`endif
`endif

[hdl/cfa_pkg.sv]
package cfa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int ADDRESS_BITS_DEF = 20;
    localparam int OWNER_BITS_DEF   = 16;

    localparam int SIZE_W  = ADDRESS_BITS_DEF + 1;
    localparam int START_W = ADDRESS_BITS_DEF;
    localparam int OWNER_W = OWNER_BITS_DEF;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_BAD   = 2'd3;

    localparam logic [1:0] ST_GRANTED    = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_BAD_POLICY = 2'd3;

    typedef struct packed {
        logic [OWNER_W-1:0] owner_id;
        logic [SIZE_W-1:0]  request_size;
        logic [1:0]         fit_policy;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] grant_start;
        logic [SIZE_W-1:0]  free_left;
    } rsp_t;

endpackage

[hdl/cfa_cell.sv]
// One table slot. A token walks the row one slot per cycle during the scan;
// during a split every slot after the insertion point takes its left
// neighbor's contents in the same cycle.
module cfa_cell #(
    parameter int AW = 20,
    parameter int OW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          init,       // reinit to empty slot
    input  logic          init_first, // this slot holds the whole memory
    input  logic [AW:0]   init_len,
    input  logic          shift_en,   // take left neighbor
    input  logic [AW-1:0] left_start,
    input  logic [AW:0]   left_len,
    input  logic          left_used,
    input  logic [OW-1:0] left_owner,
    input  logic          wr_en,      // direct write
    input  logic [AW-1:0] wr_start,
    input  logic [AW:0]   wr_len,
    input  logic          wr_used,
    input  logic [OW-1:0] wr_owner,
    output logic [AW-1:0] seg_start,
    output logic [AW:0]   seg_len,
    output logic          seg_used,
    output logic [OW-1:0] seg_owner
);
    logic [AW-1:0] start_reg;
    logic [AW:0]   len_reg;
    logic          used_reg;
    logic [OW-1:0] owner_reg;

    // used mark is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (init)
        begin
            used_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            used_reg <= wr_used;
        end
        else if (shift_en)
        begin
            used_reg <= left_used;
        end
    end

    // payload, first slot covers the full address space on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            len_reg   <= init_first ? {1'b1, {AW{1'b0}}} : '0;
        end
        else if (init)
        begin
            start_reg <= '0;
            len_reg   <= init_first ? init_len : '0;
        end
        else if (wr_en)
        begin
            start_reg <= wr_start;
            len_reg   <= wr_len;
        end
        else if (shift_en)
        begin
            start_reg <= left_start;
            len_reg   <= left_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_reg <= wr_owner;
        end
        else if (shift_en)
        begin
            owner_reg <= left_owner;
        end
    end

    assign seg_start = start_reg;
    assign seg_len   = len_reg;
    assign seg_used  = used_reg;
    assign seg_owner = owner_reg;
endmodule

[hdl/contiguous_fit_allocator_core.sv]
// Contiguous fit allocator.
// Request channel: req_valid / req_stall / req (owner, size, policy).
// Result channel: rsp_valid / rsp_stall / rsp (status, start, free total).
// One request is handled at a time. A request scans the segment table one
// slot per cycle (up to segment_count slots, at most MAX_SEGMENTS), then
// makes the update, where a split shifts every later slot right by one in
// a single step, and then loads the result register.
// A request refused without a scan goes straight to the update. A new
// request is taken only after the result is loaded. That result waits in
// the output register while the receiver stalls and the next scan may run,
// but no further result is loaded until it is taken.
// Reset (rst_n, async, active low) leaves one free segment covering
// 2^ADDRESS_BITS units. Writing memory_size (cfg_we / cfg_data, saturated
// at 2^ADDRESS_BITS) rebuilds the table the same way; write only when idle.
module contiguous_fit_allocator_core #(
    parameter int MAX_SEGMENTS = cfa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cfa_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  cfa_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output cfa_pkg::rsp_t              rsp
);
    import cfa_pkg::*;
`include "assert_macros.svh"

    localparam int AW = START_W;
    localparam int OW = OWNER_W;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [AW:0] MEM_LIMIT = {1'b1, {AW{1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [AW:0]   mem_size_reg;
    logic [AW:0]   free_reg;
    logic          found_reg;
    logic [IW-1:0] pick_reg;
    logic [AW:0]   pick_len_reg;
    logic [OW-1:0] owner_reg;
    logic [AW:0]   size_reg;
    logic [1:0]    pol_reg;
    logic [1:0]    res_status_reg;
    logic [AW-1:0] res_start_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;

    logic [AW-1:0] c_start [MAX_SEGMENTS];
    logic [AW:0]   c_len   [MAX_SEGMENTS];
    logic          c_used  [MAX_SEGMENTS];
    logic [OW-1:0] c_owner [MAX_SEGMENTS];
    logic          c_shift [MAX_SEGMENTS];
    logic          c_wr    [MAX_SEGMENTS];
    logic [AW-1:0] w_start [MAX_SEGMENTS];
    logic [AW:0]   w_len   [MAX_SEGMENTS];
    logic          w_used  [MAX_SEGMENTS];
    logic [OW-1:0] w_owner [MAX_SEGMENTS];

    logic [AW:0]   cfg_sat;
    logic          req_fire;
    logic          do_grant;
    logic          do_split;
    logic [AW:0]   rest;
    logic [IW-1:0] scan_idx;
    logic [AW:0]   scan_len;
    logic          scan_ok;
    logic          scan_take;

    assign cfg_sat   = (cfg_data[SIZE_W-1:0] > SIZE_W'(MEM_LIMIT)) ? MEM_LIMIT
                       : (AW+1)'(cfg_data);
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;

    // scan view of the slot under the token
    assign scan_idx  = idx_reg[IW-1:0];
    assign scan_len  = c_len[scan_idx];
    assign scan_ok   = !c_used[scan_idx] && (scan_len >= size_reg);
    assign scan_take = scan_ok && (!found_reg
                       || (pol_reg == POL_BEST  && scan_len < pick_len_reg)
                       || (pol_reg == POL_WORST && scan_len > pick_len_reg));

    // update decision
    assign rest     = pick_len_reg - size_reg;
    assign do_grant = (state_reg == S_UPD) && found_reg && (pol_reg != POL_BAD)
                      && !((rest != '0) && (count_reg == CW'(MAX_SEGMENTS)));
    assign do_split = do_grant && (rest != '0);

    // row of cells
    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign c_shift[g] = 1'b0;
            end
            else
            begin : g_rest
                assign c_shift[g] = do_split && (IW'(g) > pick_reg + IW'(1));
            end
            always_comb
            begin
                c_wr[g]    = 1'b0;
                w_start[g] = c_start[g];
                w_len[g]   = size_reg;
                w_used[g]  = 1'b1;
                w_owner[g] = owner_reg;
                if (do_grant && pick_reg == IW'(g))
                begin
                    c_wr[g] = 1'b1;
                end
                else if (do_split && (g > 0) && pick_reg == IW'(g - 1))
                begin
                    c_wr[g]    = 1'b1;
                    w_start[g] = c_start[(g > 0) ? g - 1 : 0] + size_reg[AW-1:0];
                    w_len[g]   = rest;
                    w_used[g]  = 1'b0;
                    w_owner[g] = '0;
                end
            end
            cfa_cell #(.AW(AW), .OW(OW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .init       (cfg_we),
                .init_first (g == 0),
                .init_len   (cfg_sat),
                .shift_en   (c_shift[g]),
                .left_start (c_start[(g > 0) ? g - 1 : 0]),
                .left_len   (c_len[(g > 0) ? g - 1 : 0]),
                .left_used  (c_used[(g > 0) ? g - 1 : 0]),
                .left_owner (c_owner[(g > 0) ? g - 1 : 0]),
                .wr_en      (c_wr[g]),
                .wr_start   (w_start[g]),
                .wr_len     (w_len[g]),
                .wr_used    (w_used[g]),
                .wr_owner   (w_owner[g]),
                .seg_start  (c_start[g]),
                .seg_len    (c_len[g]),
                .seg_used   (c_used[g]),
                .seg_owner  (c_owner[g])
            );
        end
    endgenerate

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CW'(1);
            idx_reg        <= '0;
            mem_size_reg   <= MEM_LIMIT;
            free_reg       <= MEM_LIMIT;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_GRANTED;
        end
        else
        begin
            // a result loaded in S_OUT replaces the one being taken
            if (out_valid_reg && !rsp_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                mem_size_reg <= cfg_sat;
                free_reg     <= cfg_sat;
                count_reg    <= CW'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (req.fit_policy == POL_BAD
                                      || req.request_size == '0
                                      || req.request_size > SIZE_W'(MEM_LIMIT))
                                     ? S_UPD : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_take)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (idx_reg + CW'(1) >= count_reg
                        || (pol_reg == POL_FIRST && scan_ok))
                    begin
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_UPD:
                begin
                    if (pol_reg == POL_BAD)
                    begin
                        res_status_reg <= ST_BAD_POLICY;
                    end
                    else if (!found_reg)
                    begin
                        res_status_reg <= ST_NO_FIT;
                    end
                    else if (!do_grant)
                    begin
                        res_status_reg <= ST_TABLE_FULL;
                    end
                    else
                    begin
                        res_status_reg <= ST_GRANTED;
                        free_reg       <= free_reg - size_reg;
                    end
                    if (do_split)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !rsp_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            owner_reg <= req.owner_id[OW-1:0];
            size_reg  <= (req.request_size > SIZE_W'(MEM_LIMIT)) ? MEM_LIMIT
                         : (AW+1)'(req.request_size);
            pol_reg   <= req.fit_policy;
        end
        if (state_reg == S_SCAN && scan_take)
        begin
            pick_reg     <= scan_idx;
            pick_len_reg <= scan_len;
        end
        if (state_reg == S_UPD)
        begin
            res_start_reg <= do_grant ? c_start[pick_reg] : '0;
        end
        if (state_reg == S_OUT && (!out_valid_reg || !rsp_stall))
        begin
            out_reg.status      <= res_status_reg;
            out_reg.grant_start <= START_W'(res_start_reg);
            out_reg.free_left   <= SIZE_W'(free_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ASSERT_ALWAYS(a_count_range, (count_reg >= CW'(1) && count_reg <= CW'(MAX_SEGMENTS)), "segment count out of range")
    `ASSERT_ALWAYS(a_free_le_mem, (free_reg <= mem_size_reg), "free total exceeds memory size")
    `ASSERT_CLK(a_split_room, (do_split |-> count_reg < CW'(MAX_SEGMENTS)), "split with full table")
    `ASSERT_CLK(a_scan_bound, ((state_reg == S_SCAN) |-> (idx_reg < count_reg)), "scan past table end")
endmodule
